[sv/pbpa_pkg.sv]
package pbpa_pkg;

    localparam int CMD_W       = 2;
    localparam int HANDLE_W    = 12;
    localparam int STATUS_W    = 2;
    localparam int OFFSET_W    = 20;
    localparam int COUNT_W     = 13;
    localparam int PAGES_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int ALIGN_W     = 4;

    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAGES  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_SLOT = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_SIZE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALIGN     = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DATA_SIZE_RST = 17'd16;
    localparam logic [CFG_DATA_W-1:0] PAGE_SIZE_RST = 17'd4096;
    localparam logic [ALIGN_W-1:0]    ALIGN_RST     = 4'd3;

    localparam logic [COUNT_W-1:0]    COUNT_MAX = 13'h1FFF;
    localparam logic [CFG_DATA_W-1:0] BYTES_MAX = 17'h1FFFF;

endpackage

[sv/paged_block_pool_allocator.sv]
// Free, unused command and failed allocate answer directly; free-all recomputes the
// geometry with the DIV_W-bit divider (17 by default), skipped when the page is below
// its header; allocate splits the granted handle by repeated subtract, after linking
// a new page's slots when the free list is empty.
// One request at a time: input is ready again as the result turns valid. After reset
// (async, active low) the geometry is computed from the reset register values.
module paged_block_pool_allocator #(
    parameter int MAX_PAGES         = 16,
    parameter int MAX_SLOTS         = 256,
    parameter int LINK_HEADER_BYTES = 8,
    parameter int PAGE_HEADER_BYTES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pbpa_pkg::CMD_W-1:0]        command,
    input  logic [pbpa_pkg::HANDLE_W-1:0]     block_handle,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pbpa_pkg::STATUS_W-1:0]     status,
    output logic [pbpa_pkg::HANDLE_W-1:0]     granted_handle,
    output logic [pbpa_pkg::OFFSET_W-1:0]     byte_offset,
    output logic [pbpa_pkg::COUNT_W-1:0]      free_blocks,
    output logic [pbpa_pkg::COUNT_W-1:0]      total_blocks,
    output logic [pbpa_pkg::PAGES_W-1:0]      pages_open,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pbpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pbpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import pbpa_pkg::*;

    localparam int LINK_DEPTH = MAX_PAGES * MAX_SLOTS;
    localparam int LW    = $clog2(LINK_DEPTH + 1);
    localparam int AW    = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
    localparam int PCW   = $clog2(MAX_PAGES + 1);
    localparam int SW    = $clog2(MAX_SLOTS + 1);
    localparam int PGW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SLW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int MA    = (PGW > SLW) ? PGW : SLW;
    localparam int DIV_W = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;

    localparam logic [LW-1:0]         NULL_LINK = LW'(LINK_DEPTH);
    localparam logic [CFG_DATA_W-1:0] PAGE_HDR  = CFG_DATA_W'(PAGE_HEADER_BYTES);
    localparam logic [CFG_DATA_W-1:0] LINK_HDR  = CFG_DATA_W'(LINK_HEADER_BYTES);

    typedef enum logic [9:0] {
        S_GEOM      = 10'b0000000001,
        S_GEOM_WAIT = 10'b0000000010,
        S_IDLE      = 10'b0000000100,
        S_FILL      = 10'b0000001000,
        S_POP       = 10'b0000010000,
        S_LINK      = 10'b0000100000,
        S_DIV       = 10'b0001000000,
        S_MUL_PG    = 10'b0010000000,
        S_MUL_SL    = 10'b0100000000,
        S_DONE      = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // control state
    logic                  out_valid_reg;
    logic                  init_done_reg;
    logic                  sum_pending_reg;
    logic [LW-1:0]         free_head_reg;
    logic [PCW-1:0]        page_cnt_reg;
    logic [COUNT_W-1:0]    total_cnt_reg;
    logic [COUNT_W-1:0]    free_cnt_reg;
    logic [CFG_DATA_W-1:0] data_size_reg;
    logic [CFG_DATA_W-1:0] page_size_reg;
    logic [ALIGN_W-1:0]    align_reg;
    logic [CFG_DATA_W-1:0] block_bytes_reg;
    logic [CFG_DATA_W-1:0] page_bytes_reg;
    logic [SW-1:0]         slots_reg;

    // payload state
    logic [SW-1:0]         fill_idx_reg;
    logic [LW-1:0]         base_reg;
    logic [LW-1:0]         h_reg;
    logic [LW-1:0]         split_rem_reg;
    logic [PGW-1:0]        pg_reg;
    logic [SLW-1:0]        sl_reg;
    logic [OFFSET_W-1:0]   prod_reg;
    logic [OFFSET_W-1:0]   acc_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [LW-1:0]         res_grant_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [HANDLE_W-1:0]   granted_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [COUNT_W-1:0]    free_out_reg;
    logic [COUNT_W-1:0]    total_out_reg;
    logic [PAGES_W-1:0]    pages_out_reg;

    logic in_fire;
    logic cfg_fire;
    logic out_free;
    logic head_null;
    logic no_slots;
    logic pages_full;
    logic page_small;
    logic split_more;

    // block size: max(data, link header) rounded up to the alignment
    logic [CFG_DATA_W-1:0] need;
    logic [CFG_DATA_W:0]   align_mask;
    logic [CFG_DATA_W:0]   bb_round;
    logic [CFG_DATA_W-1:0] bb_calc;

    logic [31:0] handle_ext;
    logic        handle_ok;
    logic [31:0] base_calc;
    logic [31:0] fill_pos;
    logic [31:0] fill_pos_next;
    logic        fill_last;
    logic [LW-1:0] fill_link;
    logic [31:0] grant_ext;
    logic [31:0] pages_ext;

    logic [COUNT_W:0] total_sum;
    logic [COUNT_W:0] free_sum;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quo;
    logic             div_done;

    logic [MA-1:0]         mul_a;
    logic [CFG_DATA_W-1:0] mul_b;
    logic [MA+CFG_DATA_W-1:0] mul_p;
    logic [31:0]           mul_ext;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [LW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [LW-1:0] ram_rd_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign head_null  = (free_head_reg == NULL_LINK);
    assign no_slots   = (slots_reg == '0);
    assign pages_full = (32'(page_cnt_reg) >= 32'(MAX_PAGES));
    assign page_small = (page_size_reg < PAGE_HDR);
    assign split_more = (split_rem_reg >= LW'(MAX_SLOTS));

    assign need       = (data_size_reg > LINK_HDR) ? data_size_reg : LINK_HDR;
    assign align_mask = ((CFG_DATA_W + 1)'(1) << align_reg) - 1'b1;
    assign bb_round   = ({1'b0, need} + align_mask) & ~align_mask;
    assign bb_calc    = (bb_round > {1'b0, BYTES_MAX} || bb_round == '0)
                        ? BYTES_MAX : bb_round[CFG_DATA_W-1:0];

    assign handle_ext    = 32'(block_handle);
    assign handle_ok     = (handle_ext < 32'(LINK_DEPTH));
    assign base_calc     = 32'(page_cnt_reg) * 32'(MAX_SLOTS);
    assign fill_pos      = 32'(base_reg) + 32'(fill_idx_reg);
    assign fill_pos_next = fill_pos + 32'd1;
    assign fill_last     = ((32'(fill_idx_reg) + 32'd1) == 32'(slots_reg));
    assign fill_link     = fill_last ? NULL_LINK : fill_pos_next[LW-1:0];
    assign grant_ext     = 32'(res_grant_reg);
    assign pages_ext     = 32'(page_cnt_reg);

    assign total_sum = {1'b0, total_cnt_reg} + (COUNT_W + 1)'(slots_reg);
    assign free_sum  = {1'b0, free_cnt_reg} + (COUNT_W + 1)'(slots_reg);

    // shared divider: page geometry at reset and on free-all
    assign div_start    = (state_reg == S_GEOM) && !page_small;
    assign div_dividend = DIV_W'(page_size_reg - PAGE_HDR);
    assign div_divisor  = DIV_W'(bb_calc);

    pbpa_div #(
        .W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .done      (div_done)
    );

    assign mul_a   = (state_reg == S_MUL_PG) ? MA'(pg_reg) : MA'(sl_reg);
    assign mul_b   = (state_reg == S_MUL_PG) ? page_bytes_reg : block_bytes_reg;
    assign mul_p   = mul_a * mul_b;
    assign mul_ext = 32'(mul_p);

    assign ram_wr_en   = (state_reg == S_FILL) ||
                         (in_fire && command == CMD_FREE && handle_ok);
    assign ram_wr_addr = (state_reg == S_FILL) ? fill_pos[AW-1:0] : handle_ext[AW-1:0];
    assign ram_wr_data = (state_reg == S_FILL) ? fill_link : free_head_reg;
    assign ram_rd_en   = (state_reg == S_POP);

    pbpa_link_ram #(
        .DEPTH (LINK_DEPTH),
        .AW    (AW),
        .DW    (LW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (free_head_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_GEOM:
            begin
                if (page_small)
                begin
                    state_next = init_done_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    state_next = S_GEOM_WAIT;
                end
            end
            S_GEOM_WAIT:
            begin
                if (div_done)
                begin
                    state_next = init_done_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (command)
                        CMD_ALLOC:
                        begin
                            if (!head_null)
                            begin
                                state_next = S_POP;
                            end
                            else if (no_slots || pages_full)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FILL;
                            end
                        end
                        CMD_FREE_ALL: state_next = S_GEOM;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_FILL:
            begin
                if (fill_last)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:    state_next = S_LINK;
            S_LINK:   state_next = S_DIV;
            S_DIV:
            begin
                if (!split_more)
                begin
                    state_next = S_MUL_PG;
                end
            end
            S_MUL_PG: state_next = S_MUL_SL;
            S_MUL_SL: state_next = S_DONE;
            S_DONE:
            begin
                // final add of the slot term lands in the first DONE cycle
                if (out_free && !sum_pending_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_GEOM;
            out_valid_reg   <= 1'b0;
            init_done_reg   <= 1'b0;
            sum_pending_reg <= 1'b0;
            free_head_reg   <= NULL_LINK;
            page_cnt_reg    <= '0;
            total_cnt_reg   <= '0;
            free_cnt_reg    <= '0;
            data_size_reg   <= DATA_SIZE_RST;
            page_size_reg   <= PAGE_SIZE_RST;
            align_reg       <= ALIGN_RST;
            block_bytes_reg <= '0;
            page_bytes_reg  <= '0;
            slots_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                unique case (cfg_index)
                    CFG_DATA_SIZE: data_size_reg <= cfg_data;
                    CFG_PAGE_SIZE: page_size_reg <= cfg_data;
                    CFG_ALIGN:     align_reg     <= cfg_data[ALIGN_W-1:0];
                    default:       ;
                endcase
            end

            if (state_reg == S_GEOM)
            begin
                block_bytes_reg <= bb_calc;
                page_bytes_reg  <= page_size_reg;
                if (page_small)
                begin
                    slots_reg     <= '0;
                    init_done_reg <= 1'b1;
                end
            end

            if (state_reg == S_GEOM_WAIT && div_done)
            begin
                slots_reg     <= (div_quo > DIV_W'(MAX_SLOTS)) ? SW'(MAX_SLOTS)
                                                               : div_quo[SW-1:0];
                init_done_reg <= 1'b1;
            end

            if (in_fire)
            begin
                if (command == CMD_FREE && handle_ok)
                begin
                    free_head_reg <= handle_ext[LW-1:0];
                    if (free_cnt_reg != COUNT_MAX)
                    begin
                        free_cnt_reg <= free_cnt_reg + 1'b1;
                    end
                end
                else if (command == CMD_FREE_ALL)
                begin
                    free_head_reg <= NULL_LINK;
                    page_cnt_reg  <= '0;
                    total_cnt_reg <= '0;
                    free_cnt_reg  <= '0;
                end
            end

            if (state_reg == S_FILL && fill_last)
            begin
                free_head_reg <= base_reg;
                page_cnt_reg  <= page_cnt_reg + 1'b1;
                total_cnt_reg <= total_sum[COUNT_W-1:0];
                free_cnt_reg  <= free_sum[COUNT_W] ? COUNT_MAX : free_sum[COUNT_W-1:0];
            end

            if (state_reg == S_LINK)
            begin
                free_head_reg <= ram_rd_data;
                if (free_cnt_reg != '0)
                begin
                    free_cnt_reg <= free_cnt_reg - 1'b1;
                end
            end

            if (state_reg == S_MUL_SL)
            begin
                sum_pending_reg <= 1'b1;
            end
            else if (state_reg == S_DONE)
            begin
                sum_pending_reg <= 1'b0;
            end

            if (state_reg == S_DONE && out_free && !sum_pending_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_status_reg <= ST_OK;
            res_grant_reg  <= '0;
            acc_reg        <= '0;
            fill_idx_reg   <= '0;
            base_reg       <= base_calc[LW-1:0];
            if (command == CMD_ALLOC && head_null)
            begin
                if (no_slots)
                begin
                    res_status_reg <= ST_ZERO_SLOT;
                end
                else if (pages_full)
                begin
                    res_status_reg <= ST_NO_PAGES;
                end
            end
        end

        if (state_reg == S_FILL)
        begin
            fill_idx_reg <= fill_idx_reg + 1'b1;
        end

        if (state_reg == S_POP)
        begin
            h_reg         <= free_head_reg;
            split_rem_reg <= free_head_reg;
            pg_reg        <= '0;
        end

        // page and slot of the handle: subtract one page stride per cycle
        if (state_reg == S_DIV)
        begin
            if (split_more)
            begin
                split_rem_reg <= split_rem_reg - LW'(MAX_SLOTS);
                pg_reg        <= pg_reg + 1'b1;
            end
            else
            begin
                sl_reg <= split_rem_reg[SLW-1:0];
            end
        end

        if (state_reg == S_MUL_PG)
        begin
            prod_reg <= mul_ext[OFFSET_W-1:0];
        end

        if (state_reg == S_MUL_SL)
        begin
            acc_reg       <= OFFSET_W'(PAGE_HEADER_BYTES) + prod_reg;
            prod_reg      <= mul_ext[OFFSET_W-1:0];
            res_grant_reg <= h_reg;
        end

        if (state_reg == S_DONE && sum_pending_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end

        if (state_reg == S_DONE && out_free && !sum_pending_reg)
        begin
            status_reg    <= res_status_reg;
            granted_reg   <= grant_ext[HANDLE_W-1:0];
            offset_reg    <= acc_reg;
            free_out_reg  <= free_cnt_reg;
            total_out_reg <= total_cnt_reg;
            pages_out_reg <= pages_ext[PAGES_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_handle = granted_reg;
    assign byte_offset    = offset_reg;
    assign free_blocks    = free_out_reg;
    assign total_blocks   = total_out_reg;
    assign pages_open     = pages_out_reg;

endmodule

[sv/pbpa_div.sv]
module pbpa_div #(
    parameter int W = 17
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic         done
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  div_reg;

    logic [W:0]    rem_shift;
    logic [W:0]    diff;

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign diff      = rem_shift - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign quotient  = quo_reg;
    assign done      = done_reg;

endmodule

[sv/pbpa_link_ram.sv]
module pbpa_link_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 13
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
